// ===== rtl/core/bardec_pkg.sv =====
package bardec_pkg;

    // Arithmetic coder constants
    localparam int unsigned SPLIT_SHIFT = 12;
    localparam int unsigned MAX_SHIFTS  = 4;
    localparam logic [31:0] LOW_RESET   = 32'h0000_0000;
    localparam logic [31:0] HIGH_RESET  = 32'hffff_ffff;
    localparam logic [31:0] CODE_RESET  = 32'h0000_0000;

    // Item function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    // Framer bit positions
    localparam logic [2:0] POS_FLAG      = 3'd0;
    localparam logic [2:0] POS_FIRST     = 3'd1;
    localparam logic [2:0] POS_LAST_DATA = 3'd7;

    typedef struct packed {
        logic        func;
        logic [11:0] prediction;
        logic [7:0]  code_byte;
    } in_item_t;

    typedef struct packed {
        logic       bit_res;
        logic [2:0] bytes_needed;
    } coder_res_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       stream_end;
    } frame_res_t;

    typedef struct packed {
        coder_res_t coder;
        frame_res_t frame;
    } out_item_t;

endpackage

// ===== rtl/core/bardec_if.sv =====
interface bardec_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [11:0] prediction;
    logic [7:0]  code_byte;

    modport source (output valid, output func, output prediction, output code_byte,
                    input ready);
    modport sink   (input valid, input func, input prediction, input code_byte,
                    output ready);
endinterface

interface bardec_out_if;
    logic       valid;
    logic       ready;
    logic       bit_res;
    logic [2:0] bytes_needed;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output bit_res, output bytes_needed,
                    output byte_valid, output data_byte, output stream_end,
                    input ready);
    modport sink   (input valid, input bit_res, input bytes_needed,
                    input byte_valid, input data_byte, input stream_end,
                    output ready);
endinterface

// ===== rtl/core/bardec_coder.sv =====
module bardec_coder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  bardec_pkg::in_item_t  item,
    output bardec_pkg::coder_res_t res
);
    import bardec_pkg::*;

    logic [31:0] range_low_reg, range_low_next;
    logic [31:0] range_high_reg, range_high_next;
    logic [31:0] code_value_reg, code_value_next;

    logic [31:0] span;
    logic [31:0] step;
    logic [31:0] mid;
    logic        bit_one;
    logic [31:0] low_split, high_split;
    logic [31:0] diff;
    logic [2:0]  shifts;

    // Split the interval
    assign span = range_high_reg - range_low_reg;
    assign step = {12'd0, span[31:SPLIT_SHIFT]} * {20'd0, item.prediction};
    assign mid  = range_low_reg + step;

    assign bit_one    = (code_value_reg <= mid);
    assign low_split  = bit_one ? range_low_reg : mid + 32'd1;
    assign high_split = bit_one ? mid : range_high_reg;

    // Count leading equal bytes, at most four
    assign diff = low_split ^ high_split;

    always_comb
    begin
        if (diff[31:24] != 8'd0)
            shifts = 3'd0;
        else if (diff[23:16] != 8'd0)
            shifts = 3'd1;
        else if (diff[15:8] != 8'd0)
            shifts = 3'd2;
        else if (diff[7:0] != 8'd0)
            shifts = 3'd3;
        else
            shifts = 3'(MAX_SHIFTS);
    end

    // Shift out equal bytes and load archive bytes
    always_comb
    begin
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        code_value_next = code_value_reg;
        if (fire)
        begin
            if (item.func == FUNC_LOAD)
            begin
                code_value_next = {code_value_reg[23:0], item.code_byte};
            end
            else
            begin
                case (shifts)
                    3'd0:
                    begin
                        range_low_next  = low_split;
                        range_high_next = high_split;
                    end
                    3'd1:
                    begin
                        range_low_next  = {low_split[23:0], 8'h00};
                        range_high_next = {high_split[23:0], 8'hff};
                    end
                    3'd2:
                    begin
                        range_low_next  = {low_split[15:0], 16'h0000};
                        range_high_next = {high_split[15:0], 16'hffff};
                    end
                    3'd3:
                    begin
                        range_low_next  = {low_split[7:0], 24'h000000};
                        range_high_next = {high_split[7:0], 24'hffffff};
                    end
                    default:
                    begin
                        range_low_next  = LOW_RESET;
                        range_high_next = HIGH_RESET;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= LOW_RESET;
            range_high_reg <= HIGH_RESET;
            code_value_reg <= CODE_RESET;
        end
        else
        begin
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
            code_value_reg <= code_value_next;
        end
    end

    assign res.bit_res      = bit_one;
    assign res.bytes_needed = shifts;

endmodule

// ===== rtl/core/bardec_framer.sv =====
module bardec_framer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire_decode,
    input  logic                   bit_res,
    output bardec_pkg::frame_res_t res
);
    import bardec_pkg::*;

    logic [2:0] bit_position_reg, bit_position_next;
    logic [7:0] byte_acc_reg, byte_acc_next;
    logic       ended_reg, ended_next;
    logic [7:0] acc_shifted;

    assign acc_shifted = {byte_acc_reg[6:0], bit_res};

    // Advance the framing on each decoded bit until the stream ends
    always_comb
    begin
        bit_position_next = bit_position_reg;
        byte_acc_next     = byte_acc_reg;
        ended_next        = ended_reg;
        res.byte_valid    = 1'b0;
        res.data_byte     = 8'd0;
        if (!ended_reg)
        begin
            if (bit_position_reg == POS_FLAG)
            begin
                if (bit_res)
                begin
                    ended_next = 1'b1;
                end
                else
                begin
                    bit_position_next = POS_FIRST;
                    byte_acc_next     = 8'd0;
                end
            end
            else
            begin
                byte_acc_next = acc_shifted;
                if (bit_position_reg == POS_LAST_DATA)
                begin
                    res.byte_valid    = 1'b1;
                    res.data_byte     = acc_shifted;
                    bit_position_next = POS_FLAG;
                end
                else
                begin
                    bit_position_next = bit_position_reg + 3'd1;
                end
            end
        end
        res.stream_end = ended_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_position_reg <= POS_FLAG;
            byte_acc_reg     <= 8'd0;
            ended_reg        <= 1'b0;
        end
        else if (fire_decode)
        begin
            bit_position_reg <= bit_position_next;
            byte_acc_reg     <= byte_acc_next;
            ended_reg        <= ended_next;
        end
    end

endmodule

// ===== rtl/core/binary_arithmetic_decoder_top.sv =====
// Channel   Dir  Payload                                                Result
// symbol    in   func, prediction[11:0], code_byte[7:0]                 load or decode one bit
// result    out  bit_res, bytes_needed[2:0], byte_valid, data_byte[7:0], stream_end
//
// One item per cycle unless result stalls. An accepted beat lands in the input
// register; once the output register is free, the interval split (one 20x12
// multiply, add, compare, byte shift) runs and the decode result is registered.
// Load beats update the code window and produce no result beat.
// rst_n clears the interval, code window, framing state and both valid flags.
// A stalled result holds the output register and the beat in the input
// register, load or decode, so symbol stalls once that register is full; the
// input register drains in the same cycle that result.ready rises.
module binary_arithmetic_decoder_top (
    input logic         clk,
    input logic         rst_n,
    bardec_in_if.sink   symbol,
    bardec_out_if.source result
);
    import bardec_pkg::*;

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg;
    logic       fire;
    logic       fire_decode;
    coder_res_t coder_res;
    frame_res_t frame_res;

    // Process the held beat whenever the output register is free to take it
    assign fire          = in_valid_reg && (!out_valid_reg || result.ready);
    assign fire_decode   = fire && (in_item_reg.func == FUNC_DECODE);
    assign symbol.ready  = !in_valid_reg || fire;

    bardec_coder u_coder (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .res   (coder_res)
    );

    bardec_framer u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire_decode (fire_decode),
        .bit_res     (coder_res.bit_res),
        .res         (frame_res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (symbol.ready)
            in_valid_reg <= symbol.valid;
    end

    always_ff @(posedge clk)
    begin
        if (symbol.ready && symbol.valid)
        begin
            in_item_reg.func       <= symbol.func;
            in_item_reg.prediction <= symbol.prediction;
            in_item_reg.code_byte  <= symbol.code_byte;
        end
    end

    // Output register: load on decode, drop when taken
    always_comb
    begin
        if (fire_decode)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire_decode)
        begin
            out_item_reg.coder <= coder_res;
            out_item_reg.frame <= frame_res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.bit_res      = out_item_reg.coder.bit_res;
    assign result.bytes_needed = out_item_reg.coder.bytes_needed;
    assign result.byte_valid   = out_item_reg.frame.byte_valid;
    assign result.data_byte    = out_item_reg.frame.data_byte;
    assign result.stream_end   = out_item_reg.frame.stream_end;

endmodule
